FILE: rtl/core/plm_pkg.sv
package plm_pkg;

    // Sample width codes of the sample_size register
    typedef enum logic [1:0] {
        SIZE_8  = 2'd0,
        SIZE_16 = 2'd1,
        SIZE_24 = 2'd2,
        SIZE_32 = 2'd3
    } size_t;

    // Configuration register indexes
    localparam logic [1:0] REG_SAMPLE_SIZE      = 2'd0;
    localparam logic [1:0] REG_UNSIGNED_SAMPLES = 2'd1;
    localparam logic [1:0] REG_BIG_ENDIAN       = 2'd2;
    localparam logic [1:0] REG_STEREO           = 2'd3;

    localparam int unsigned PEAK_W = 31;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned DIV_W  = 25;
    localparam int unsigned RCP_W  = 16;

    localparam logic [PEAK_W-1:0] PEAK_MAX = 31'h7fff_ffff;
    localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;

    // Full scale / 100 for the wide formats, and floor(2^32 / that divisor)
    localparam logic [DIV_W-1:0] DIV_24   = 25'd83886;
    localparam logic [DIV_W-1:0] DIV_32   = 25'd21474836;
    localparam logic [RCP_W-1:0] RECIP_24 = 16'd51200;
    localparam logic [RCP_W-1:0] RECIP_32 = 16'd200;

    typedef struct packed {
        size_t size;
        logic  unsigned_samples;
        logic  big_endian;
        logic  stereo;
    } cfg_t;

    // Load strobes of the percent pipeline stages
    typedef struct packed {
        logic d_load;
        logic e_load;
    } pct_ctl_t;

endpackage

FILE: rtl/core/pcm_peak_level_meter.sv
// PCM peak level meter.
// Slave stream (s_*): one raw sample word per request, bytes in memory order,
// s_tlast on the final sample of a chunk. Master stream (m_*): one request per
// chunk, carrying both channel peaks and their percent of full scale.
// Configuration channel (cfg_*): index 0 sample size, 1 unsigned samples,
// 2 big endian, 3 stereo; write it only while no chunk result is pending.
// Throughput: one sample per cycle while the result stream is not stalled,
// with no gaps between chunks. The result of a chunk passes the input register,
// magnitude register, peak snapshot, quotient estimate, estimate times divisor
// and remainder correction into the output register before it shows on m_tvalid.
// Reset: configuration returns to 16-bit signed little-endian mono; peaks and
// the channel toggle clear; all pipeline stages empty.
// Stall: while m_tready is low the result holds in the output register and the
// percent stages fill behind it; samples without s_tlast keep flowing into the
// peak store, and s_tready drops only when a last sample finds no free stage.
module pcm_peak_level_meter (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data,
    // Sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] sample_word
    input  logic        s_tlast,
    // Chunk result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata      // [30:0] left_peak, [61:31] right_peak,
                                     // [68:62] left_percent, [75:69] right_percent,
                                     // [79:76] zero
);

    plm_pkg::cfg_t              cfg;
    logic                       b_valid;
    logic                       b_ready;
    logic [plm_pkg::PEAK_W-1:0] b_mag;
    logic                       b_last;
    logic                       cap_valid;
    logic                       cap_ready;
    logic [plm_pkg::PEAK_W-1:0] cap_left;
    logic [plm_pkg::PEAK_W-1:0] cap_right;

    // Hold the live configuration
    plm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Register the sample, then reorder, unbias and take its magnitude
    plm_magnitude u_mag (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .b_valid  (b_valid),
        .b_ready  (b_ready),
        .b_mag    (b_mag),
        .b_last   (b_last)
    );

    // Fold the magnitude into its channel's peak; snapshot and clear on last
    plm_peak_accum u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .b_valid   (b_valid),
        .b_ready   (b_ready),
        .b_mag     (b_mag),
        .b_last    (b_last),
        .cap_valid (cap_valid),
        .cap_ready (cap_ready),
        .cap_left  (cap_left),
        .cap_right (cap_right)
    );

    // Turn the snapshot into percentages and present the result
    plm_percent u_pct (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cap_valid (cap_valid),
        .cap_ready (cap_ready),
        .cap_left  (cap_left),
        .cap_right (cap_right),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: rtl/core/plm_cfg_regs.sv
module plm_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [1:0]       cfg_data,
    output plm_pkg::cfg_t    cfg
);

    plm_pkg::cfg_t cfg_reg;
    plm_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                plm_pkg::REG_SAMPLE_SIZE:      cfg_next.size = plm_pkg::size_t'(cfg_data);
                plm_pkg::REG_UNSIGNED_SAMPLES: cfg_next.unsigned_samples = cfg_data[0];
                plm_pkg::REG_BIG_ENDIAN:       cfg_next.big_endian = cfg_data[0];
                plm_pkg::REG_STEREO:           cfg_next.stereo = cfg_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size             <= plm_pkg::SIZE_16;
            cfg_reg.unsigned_samples <= 1'b0;
            cfg_reg.big_endian       <= 1'b0;
            cfg_reg.stereo           <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/plm_magnitude.sv
module plm_magnitude (
    input  logic                        clk,
    input  logic                        rst_n,
    input  plm_pkg::cfg_t               cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,
    input  logic                        s_tlast,
    output logic                        b_valid,
    input  logic                        b_ready,
    output logic [plm_pkg::PEAK_W-1:0]  b_mag,
    output logic                        b_last
);

    logic        a_valid_reg;
    logic [31:0] a_word_reg;
    logic        a_last_reg;
    logic        b_valid_reg;
    logic [plm_pkg::PEAK_W-1:0] b_mag_reg;
    logic        b_last_reg;

    logic        a_free;
    logic        b_free;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  v8;
    logic [15:0] v16;
    logic [23:0] v24;
    logic [31:0] v32;
    logic [31:0] sx;
    logic [31:0] abs32;
    logic [plm_pkg::PEAK_W-1:0] mag_next;

    assign b_free   = !b_valid_reg || b_ready;
    assign a_free   = !a_valid_reg || b_free;
    assign s_tready = a_free;

    assign byte0 = a_word_reg[7:0];
    assign byte1 = a_word_reg[15:8];
    assign byte2 = a_word_reg[23:16];
    assign byte3 = a_word_reg[31:24];

    // Order bytes, drop the mid-scale bias on the sign bit, sign-extend
    always_comb
    begin
        v8  = byte0;
        v16 = cfg.big_endian ? {byte0, byte1} : {byte1, byte0};
        v24 = cfg.big_endian ? {byte0, byte1, byte2} : {byte2, byte1, byte0};
        v32 = cfg.big_endian ? {byte0, byte1, byte2, byte3} : {byte3, byte2, byte1, byte0};
        v8[7]   = v8[7]   ^ cfg.unsigned_samples;
        v16[15] = v16[15] ^ cfg.unsigned_samples;
        v24[23] = v24[23] ^ cfg.unsigned_samples;
        v32[31] = v32[31] ^ cfg.unsigned_samples;
        unique case (cfg.size)
            plm_pkg::SIZE_8:  sx = {{24{v8[7]}}, v8};
            plm_pkg::SIZE_16: sx = {{16{v16[15]}}, v16};
            plm_pkg::SIZE_24: sx = {{8{v24[23]}}, v24};
            plm_pkg::SIZE_32: sx = v32;
            default:          sx = v32;
        endcase
        abs32 = sx[31] ? (~sx + 32'd1) : sx;
        // Only the most negative 32-bit sample reaches 2^31: clamp it
        mag_next = abs32[31] ? plm_pkg::PEAK_MAX : abs32[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free)
        begin
            a_word_reg <= s_tdata;
            a_last_reg <= s_tlast;
        end
        if (b_free)
        begin
            b_mag_reg  <= mag_next;
            b_last_reg <= a_last_reg;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_mag   = b_mag_reg;
    assign b_last  = b_last_reg;

endmodule

FILE: rtl/core/plm_peak_accum.sv
module plm_peak_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  plm_pkg::cfg_t               cfg,
    input  logic                        b_valid,
    output logic                        b_ready,
    input  logic [plm_pkg::PEAK_W-1:0]  b_mag,
    input  logic                        b_last,
    output logic                        cap_valid,
    input  logic                        cap_ready,
    output logic [plm_pkg::PEAK_W-1:0]  cap_left,
    output logic [plm_pkg::PEAK_W-1:0]  cap_right
);

    logic [plm_pkg::PEAK_W-1:0] peak0_reg;
    logic [plm_pkg::PEAK_W-1:0] peak1_reg;
    logic                       toggle_reg;
    logic [plm_pkg::PEAK_W-1:0] peak0_next;
    logic [plm_pkg::PEAK_W-1:0] peak1_next;
    logic                       toggle_next;

    logic                       ch;
    logic                       grow;
    logic                       consume;
    logic [plm_pkg::PEAK_W-1:0] upd0;
    logic [plm_pkg::PEAK_W-1:0] upd1;

    // A last sample waits until the percent pipeline can take the snapshot
    assign b_ready   = !b_last || cap_ready;
    assign consume   = b_valid && b_ready;
    assign cap_valid = b_valid && b_last;

    assign ch   = cfg.stereo & toggle_reg;
    assign grow = ch ? (b_mag > peak1_reg) : (b_mag > peak0_reg);
    assign upd0 = (!ch && grow) ? b_mag : peak0_reg;
    assign upd1 = (ch && grow) ? b_mag : peak1_reg;

    assign cap_left  = upd0;
    assign cap_right = cfg.stereo ? upd1 : '0;

    always_comb
    begin
        peak0_next  = peak0_reg;
        peak1_next  = peak1_reg;
        toggle_next = toggle_reg;
        if (consume)
        begin
            if (b_last)
            begin
                peak0_next  = '0;
                peak1_next  = '0;
                toggle_next = 1'b0;
            end
            else
            begin
                peak0_next  = upd0;
                peak1_next  = upd1;
                toggle_next = toggle_reg ^ cfg.stereo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak0_reg  <= '0;
            peak1_reg  <= '0;
            toggle_reg <= 1'b0;
        end
        else
        begin
            peak0_reg  <= peak0_next;
            peak1_reg  <= peak1_next;
            toggle_reg <= toggle_next;
        end
    end

endmodule

FILE: rtl/core/plm_pct_lane.sv
module plm_pct_lane (
    input  logic                        clk,
    input  plm_pkg::pct_ctl_t           ctl,
    input  plm_pkg::size_t              size,
    input  logic [plm_pkg::PEAK_W-1:0]  peak,
    output logic [plm_pkg::PEAK_W-1:0]  peak_out,
    output logic [plm_pkg::PCT_W-1:0]   pct
);

    // Stage D: quotient estimate
    logic [plm_pkg::PEAK_W-1:0] d_peak_reg;
    logic [plm_pkg::PCT_W-1:0]  d_q_reg;
    logic                       d_final_reg;
    logic [plm_pkg::DIV_W-1:0]  d_div_reg;
    // Stage E: estimate times divisor
    logic [plm_pkg::PEAK_W-1:0] e_peak_reg;
    logic [plm_pkg::PCT_W-1:0]  e_q_reg;
    logic                       e_final_reg;
    logic [plm_pkg::DIV_W-1:0]  e_div_reg;
    logic [31:0]                e_qd_reg;

    logic                       is_narrow;
    logic                       narrow_over;
    logic [23:0]                narrow_prod;
    logic [7:0]                 narrow_q;
    logic [plm_pkg::RCP_W-1:0]  recip;
    logic [plm_pkg::DIV_W-1:0]  div_next;
    logic [46:0]                wide_prod;
    logic [14:0]                wide_q;
    logic                       wide_sat;
    logic [plm_pkg::PCT_W-1:0]  d_q_next;
    logic                       d_final_next;
    logic [31:0]                e_qd_next;
    logic [31:0]                rem;
    logic                       bump;
    logic [7:0]                 q_inc;

    always_comb
    begin
        is_narrow   = (size == plm_pkg::SIZE_8) || (size == plm_pkg::SIZE_16);
        // Narrow formats: full scale is a power of two, so percent is a multiply by 100 and a shift
        narrow_over = (size == plm_pkg::SIZE_8) ? (peak[30:8] != '0) : (peak[30:16] != '0);
        narrow_prod = 24'(peak[16:0]) * 24'd100;
        narrow_q    = (size == plm_pkg::SIZE_8) ? narrow_prod[14:7] : narrow_prod[22:15];
        // Wide formats: reciprocal estimate, at most one short
        recip     = (size == plm_pkg::SIZE_24) ? plm_pkg::RECIP_24 : plm_pkg::RECIP_32;
        div_next  = (size == plm_pkg::SIZE_24) ? plm_pkg::DIV_24 : plm_pkg::DIV_32;
        wide_prod = 47'(peak) * 47'(recip);
        wide_q    = wide_prod[46:32];
        wide_sat  = wide_q > 15'(plm_pkg::PCT_FULL);
        if (is_narrow)
        begin
            d_final_next = 1'b1;
            if (narrow_over || (narrow_q > 8'(plm_pkg::PCT_FULL)))
            begin
                d_q_next = plm_pkg::PCT_FULL;
            end
            else
            begin
                d_q_next = narrow_q[6:0];
            end
        end
        else
        begin
            d_final_next = wide_sat;
            d_q_next     = wide_sat ? plm_pkg::PCT_FULL : wide_q[6:0];
        end
    end

    assign e_qd_next = 32'(d_q_reg) * 32'(d_div_reg);

    // Correct the estimate by one where the remainder still covers a divisor
    always_comb
    begin
        rem   = {1'b0, e_peak_reg} - e_qd_reg;
        bump  = rem >= 32'(e_div_reg);
        q_inc = {1'b0, e_q_reg} + 8'(bump);
        if (e_final_reg)
        begin
            pct = e_q_reg;
        end
        else if (q_inc > 8'(plm_pkg::PCT_FULL))
        begin
            pct = plm_pkg::PCT_FULL;
        end
        else
        begin
            pct = q_inc[6:0];
        end
    end

    assign peak_out = e_peak_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.d_load)
        begin
            d_peak_reg  <= peak;
            d_q_reg     <= d_q_next;
            d_final_reg <= d_final_next;
            d_div_reg   <= div_next;
        end
        if (ctl.e_load)
        begin
            e_peak_reg  <= d_peak_reg;
            e_q_reg     <= d_q_reg;
            e_final_reg <= d_final_reg;
            e_div_reg   <= d_div_reg;
            e_qd_reg    <= e_qd_next;
        end
    end

endmodule

FILE: rtl/core/plm_percent.sv
module plm_percent (
    input  logic                        clk,
    input  logic                        rst_n,
    input  plm_pkg::cfg_t               cfg,
    input  logic                        cap_valid,
    output logic                        cap_ready,
    input  logic [plm_pkg::PEAK_W-1:0]  cap_left,
    input  logic [plm_pkg::PEAK_W-1:0]  cap_right,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [79:0]                 m_tdata
);

    logic                       c_valid_reg;
    logic                       d_valid_reg;
    logic                       e_valid_reg;
    logic                       o_valid_reg;
    logic [plm_pkg::PEAK_W-1:0] c_left_reg;
    logic [plm_pkg::PEAK_W-1:0] c_right_reg;
    plm_pkg::size_t             c_size_reg;
    logic [plm_pkg::PEAK_W-1:0] o_lpeak_reg;
    logic [plm_pkg::PEAK_W-1:0] o_rpeak_reg;
    logic [plm_pkg::PCT_W-1:0]  o_lpct_reg;
    logic [plm_pkg::PCT_W-1:0]  o_rpct_reg;

    logic                       o_free;
    logic                       e_free;
    logic                       d_free;
    logic                       c_free;
    plm_pkg::pct_ctl_t          ctl;
    logic [plm_pkg::PEAK_W-1:0] lpeak;
    logic [plm_pkg::PEAK_W-1:0] rpeak;
    logic [plm_pkg::PCT_W-1:0]  lpct;
    logic [plm_pkg::PCT_W-1:0]  rpct;

    assign o_free    = !o_valid_reg || m_tready;
    assign e_free    = !e_valid_reg || o_free;
    assign d_free    = !d_valid_reg || e_free;
    assign c_free    = !c_valid_reg || d_free;
    assign cap_ready = c_free;

    assign ctl.d_load = d_free;
    assign ctl.e_load = e_free;

    plm_pct_lane u_left (
        .clk      (clk),
        .ctl      (ctl),
        .size     (c_size_reg),
        .peak     (c_left_reg),
        .peak_out (lpeak),
        .pct      (lpct)
    );

    plm_pct_lane u_right (
        .clk      (clk),
        .ctl      (ctl),
        .size     (c_size_reg),
        .peak     (c_right_reg),
        .peak_out (rpeak),
        .pct      (rpct)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_free)
            begin
                c_valid_reg <= cap_valid;
            end
            if (d_free)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_free)
            begin
                e_valid_reg <= d_valid_reg;
            end
            if (o_free)
            begin
                o_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_free)
        begin
            c_left_reg  <= cap_left;
            c_right_reg <= cap_right;
            c_size_reg  <= cfg.size;
        end
        if (o_free)
        begin
            o_lpeak_reg <= lpeak;
            o_rpeak_reg <= rpeak;
            o_lpct_reg  <= lpct;
            o_rpct_reg  <= rpct;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {4'b0, o_rpct_reg, o_lpct_reg, o_rpeak_reg, o_lpeak_reg};

endmodule

FILE: tb/pcm_peak_level_meter_tb.sv
`timescale 1ns / 1ps

module pcm_peak_level_meter_tb;

    import plm_pkg::*;

    // Run length: watchdog limit for the whole run
    localparam int unsigned LIMIT_CYCLES = 600000;
    localparam int unsigned DRAIN_CYCLES = 20;   // settle time after the reports drain
    localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int unsigned RAND_ITEMS   = 1650;
    localparam int unsigned SCRIPT_ROWS  = 30;

    // One chunk report as carried on m_tdata
    typedef struct {
        logic [30:0] left_peak;
        logic [30:0] right_peak;
        logic [6:0]  left_pct;
        logic [6:0]  right_pct;
    } level_report_t;

    // Directed script row: either a register write or one sample request.
    // pinned rows carry a report typed in by hand.
    typedef struct {
        logic        is_cfg;
        logic [1:0]  reg_index;
        logic [1:0]  reg_value;
        logic [31:0] word;
        logic        last;
        logic        pinned;
        logic [30:0] lp;
        logic [30:0] rp;
        logic [6:0]  lpct;
        logic [6:0]  rpct;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [1:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    // Hand-typed report that travels with the sample on the bus
    logic          pinned_valid;
    level_report_t pinned_report;

    // Meter model state
    cfg_t        meter_cfg;
    logic [30:0] peak_hold [2];
    logic        right_turn;

    level_report_t pending_reports [$];
    int unsigned   mismatches;
    logic          burst_mode;
    logic          hold_off_req;

    // Reset: 16-bit signed little-endian mono
    script_row_t script [SCRIPT_ROWS] = '{
        '{1'b0, 2'd0, 2'd0, 32'h0000_0000, 1'b1, 1'b1, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h0000_8000, 1'b1, 1'b1, 31'd32768, 31'd0, 7'd100, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h0000_7fff, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        // high bytes above the sample width are ignored
        '{1'b0, 2'd0, 2'd0, 32'hffff_0001, 1'b1, 1'b1, 31'd32767, 31'd0, 7'd99, 7'd0},
        '{1'b1, REG_SAMPLE_SIZE, SIZE_32, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        // most negative 32-bit sample saturates
        '{1'b0, 2'd0, 2'd0, 32'h8000_0000, 1'b1, 1'b1, 31'h7fff_ffff, 31'd0, 7'd100, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'hffff_ffff, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h0000_0001, 1'b1, 1'b1, 31'd1, 31'd0, 7'd0, 7'd0},
        '{1'b1, REG_SAMPLE_SIZE, SIZE_8, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b1, REG_UNSIGNED_SAMPLES, 2'd1, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h0000_0000, 1'b1, 1'b1, 31'd128, 31'd0, 7'd100, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'hffff_ff80, 1'b1, 1'b1, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h0000_00ff, 1'b1, 1'b1, 31'd127, 31'd0, 7'd99, 7'd0},
        '{1'b1, REG_UNSIGNED_SAMPLES, 2'd0, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b1, REG_BIG_ENDIAN, 2'd1, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b1, REG_STEREO, 2'd1, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b1, REG_SAMPLE_SIZE, SIZE_24, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        // stereo, odd chunk length so the toggle clears on the left channel
        '{1'b0, 2'd0, 2'd0, 32'h0000_0080, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h1234_5678, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h0001_0000, 1'b1, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'hffff_ffff, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h0000_7f00, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        // width changes inside an open chunk; peaks and toggle carry over
        '{1'b1, REG_SAMPLE_SIZE, SIZE_16, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h0000_0180, 1'b1, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b1, REG_UNSIGNED_SAMPLES, 2'd1, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b1, REG_SAMPLE_SIZE, SIZE_32, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h0000_0080, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h0000_0000, 1'b1, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b1, REG_BIG_ENDIAN, 2'd0, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0},
        '{1'b0, 2'd0, 2'd0, 32'h7fff_ffff, 1'b1, 1'b0, 31'd0, 31'd0, 7'd0, 7'd0}
    };

    pcm_peak_level_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Magnitude of one raw sample word under the given format, clipped to 31 bits
    function automatic logic [30:0] sample_magnitude(input logic [31:0] word,
                                                     input size_t sz,
                                                     input logic uns,
                                                     input logic be);
        int unsigned nbytes;
        int unsigned w;
        logic [63:0] v;
        logic [63:0] swapped;
        logic [63:0] sign;
        logic [63:0] mag;
        nbytes = int'(sz) + 1;
        w = nbytes * 8;
        v = {32'd0, word} & ((64'd1 << w) - 64'd1);
        if (be)
        begin
            swapped = '0;
            for (int i = 0; i < nbytes; i++)
                swapped = (swapped << 8) | ((v >> (8 * i)) & 64'hff);
            v = swapped;
        end
        sign = 64'd1 << (w - 1);
        if (uns)
            v = v ^ sign;
        mag = ((v & sign) != 0) ? (64'd1 << w) - v : v;
        if (mag > 64'h7fff_ffff)
            mag = 64'h7fff_ffff;
        return mag[30:0];
    endfunction

    // Peak as percent of full scale, saturated at 100
    function automatic logic [6:0] full_scale_percent(input logic [30:0] peak, input size_t sz);
        int unsigned w;
        logic [63:0] full;
        logic [63:0] pct;
        w = (int'(sz) + 1) * 8;
        full = (w == 32) ? 64'h7fff_ffff : (64'd1 << (w - 1));
        if (w > 16)
            pct = {33'd0, peak} / (full / 64'd100);
        else
            pct = {33'd0, peak} * 64'd100 / full;
        if (pct > 64'd100)
            pct = 64'd100;
        return pct[6:0];
    endfunction

    // Fold one sample into the peak model; return 1 with the report on a chunk end
    function automatic logic account_sample(input logic [31:0] word, input logic last_flag,
                                            output level_report_t report);
        logic [30:0] mag;
        logic        ch;
        mag = sample_magnitude(word, meter_cfg.size, meter_cfg.unsigned_samples,
                               meter_cfg.big_endian);
        ch = meter_cfg.stereo ? right_turn : 1'b0;
        if (mag > peak_hold[ch])
            peak_hold[ch] = mag;
        if (meter_cfg.stereo)
            right_turn = ~right_turn;
        report = '{default: '0};
        if (!last_flag)
            return 1'b0;
        report.left_peak = peak_hold[0];
        report.left_pct  = full_scale_percent(peak_hold[0], meter_cfg.size);
        if (meter_cfg.stereo)
        begin
            report.right_peak = peak_hold[1];
            report.right_pct  = full_scale_percent(peak_hold[1], meter_cfg.size);
        end
        peak_hold[0] = '0;
        peak_hold[1] = '0;
        right_turn   = 1'b0;
        return 1'b1;
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Half fully random words, half built byte by byte, mostly from extreme bytes
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        if ($urandom_range(0, 1) == 0)
            return $urandom();
        for (int k = 0; k < 4; k++)
        begin
            case ($urandom_range(0, 4))
                0:       w[8*k +: 8] = 8'h00;
                1:       w[8*k +: 8] = 8'h7f;
                2:       w[8*k +: 8] = 8'h80;
                3:       w[8*k +: 8] = 8'hff;
                default: w[8*k +: 8] = 8'($urandom());
            endcase
        end
        return w;
    endfunction

    function automatic int unsigned chunk_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 4);
        if (r < 85)
            return $urandom_range(5, 16);
        return $urandom_range(17, 64);
    endfunction

    task automatic compare_report(input level_report_t want, input logic [79:0] bus);
        if (bus[30:0] !== want.left_peak)
        begin
            $error("left_peak: expected %0d, got %0d", want.left_peak, bus[30:0]);
            mismatches++;
        end
        if (bus[61:31] !== want.right_peak)
        begin
            $error("right_peak: expected %0d, got %0d", want.right_peak, bus[61:31]);
            mismatches++;
        end
        if (bus[68:62] !== want.left_pct)
        begin
            $error("left_percent: expected %0d, got %0d", want.left_pct, bus[68:62]);
            mismatches++;
        end
        if (bus[75:69] !== want.right_pct)
        begin
            $error("right_percent: expected %0d, got %0d", want.right_pct, bus[75:69]);
            mismatches++;
        end
        if (bus[79:76] !== 4'd0)
        begin
            $error("pad: expected 0, got %0h", bus[79:76]);
            mismatches++;
        end
    endtask

    // Watch all three channels at the rising edge. Check the result request
    // before predicting, so a report can never match its own chunk's request
    // accepted at the same edge.
    always @(posedge clk)
    begin : observe
        level_report_t predicted;
        logic          has_report;
        if (!rst_n)
        begin
            meter_cfg.size             = SIZE_16;
            meter_cfg.unsigned_samples = 1'b0;
            meter_cfg.big_endian       = 1'b0;
            meter_cfg.stereo           = 1'b0;
            peak_hold[0]               = '0;
            peak_hold[1]               = '0;
            right_turn                 = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("unexpected report: %h", m_tdata);
                    mismatches++;
                end
                else
                    compare_report(pending_reports.pop_front(), m_tdata);
            end
            if (s_tvalid && s_tready)
            begin
                has_report = account_sample(s_tdata, s_tlast, predicted);
                if (has_report)
                    pending_reports.push_back(pinned_valid ? pinned_report : predicted);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SAMPLE_SIZE:      meter_cfg.size = size_t'(cfg_data);
                    REG_UNSIGNED_SAMPLES: meter_cfg.unsigned_samples = cfg_data[0];
                    REG_BIG_ENDIAN:       meter_cfg.big_endian = cfg_data[0];
                    REG_STEREO:           meter_cfg.stereo = cfg_data[0];
                    default:              ;
                endcase
            end
        end
    end

    // Write one register once the block is idle: stop offering samples, drain
    // reports, then give an open chunk time to settle through the pipeline.
    task automatic write_register(input logic [1:0] idx, input logic [1:0] val);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Offer one sample request after an optional gap; hold it until accepted.
    // Valid stays high across back-to-back requests.
    task automatic offer_sample(input logic [31:0] word, input logic last_flag,
                                input logic pinned, input level_report_t want);
        int unsigned gap;
        gap = burst_mode ? 0 : idle_gap();
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata       = word;
        s_tlast       = last_flag;
        pinned_valid  = pinned;
        pinned_report = want;
        s_tvalid      = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: runs of ready and gaps, mostly short; drop ready for a long,
    // counted stretch when asked so the block backs up into s_tready.
    initial
    begin : receiver
        int unsigned on_len;
        int unsigned off_len;
        int unsigned k;
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready = 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                on_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                       : $urandom_range(50, 200);
                m_tready = 1'b1;
                k = 0;
                while (k < on_len && !hold_off_req)
                begin
                    @(negedge clk);
                    k++;
                end
                off_len = idle_gap();
                if (!hold_off_req && off_len != 0)
                begin
                    m_tready = 1'b0;
                    repeat (off_len) @(negedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        level_report_t want;
        int unsigned   sent;
        int unsigned   phase;
        int unsigned   n;
        int unsigned   run_left;
        logic          last_flag;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        pinned_valid  = 1'b0;
        pinned_report = '{default: '0};
        burst_mode    = 1'b0;
        hold_off_req  = 1'b0;
        mismatches    = 0;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed script: formats, extremes, stereo toggle, mid-chunk changes
        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            if (script[i].is_cfg)
                write_register(script[i].reg_index, script[i].reg_value);
            else
            begin
                want.left_peak  = script[i].lp;
                want.right_peak = script[i].rp;
                want.left_pct   = script[i].lpct;
                want.right_pct  = script[i].rpct;
                offer_sample(script[i].word, script[i].last, script[i].pinned, want);
            end
        end

        // Random phases: new format, then a run of chunks. A phase may end
        // inside a chunk, so the next format applies to the rest of it.
        want     = '{default: '0};
        sent     = 0;
        phase    = 0;
        run_left = 0;
        while (sent < RAND_ITEMS)
        begin
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_register(REG_SAMPLE_SIZE, 2'($urandom_range(0, 3)));
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_register(REG_UNSIGNED_SAMPLES, 2'($urandom_range(0, 1)));
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_register(REG_BIG_ENDIAN, 2'($urandom_range(0, 1)));
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_register(REG_STEREO, 2'($urandom_range(0, 1)));
            if (phase == 2)
            begin
                // Hold off the receiver and push one-sample chunks back to back
                burst_mode   = 1'b1;
                hold_off_req = 1'b1;
                if (run_left != 0)
                begin
                    offer_sample(random_word(), 1'b1, 1'b0, want);
                    sent++;
                    run_left = 0;
                end
                for (int j = 0; j < 40; j++)
                begin
                    offer_sample(random_word(), 1'b1, 1'b0, want);
                    sent++;
                end
            end
            else
            begin
                burst_mode = ($urandom_range(0, 4) == 0);
                n = $urandom_range(20, 60);
                for (int j = 0; j < n; j++)
                begin
                    if (run_left == 0)
                        run_left = chunk_length();
                    last_flag = (run_left == 1);
                    run_left--;
                    offer_sample(random_word(), last_flag, 1'b0, want);
                    sent++;
                end
            end
            phase++;
        end

        // Close any open chunk so its report is checked too
        burst_mode = 1'b0;
        if (run_left != 0)
            offer_sample(random_word(), 1'b1, 1'b0, want);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/plm_pkg.sv
rtl/core/plm_cfg_regs.sv
rtl/core/plm_magnitude.sv
rtl/core/plm_peak_accum.sv
rtl/core/plm_pct_lane.sv
rtl/core/plm_percent.sv
rtl/core/pcm_peak_level_meter.sv
tb/pcm_peak_level_meter_tb.sv
